@@ hdl/wsdf_pkg.sv @@
package wsdf_pkg;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_INCOMPLETE = 2'd1;
    localparam logic [1:0] STAT_ERROR      = 2'd2;

    localparam logic [3:0] OPC_TEXT   = 4'd1;
    localparam logic [3:0] OPC_BINARY = 4'd2;
    localparam logic [3:0] OPC_CLOSE  = 4'd8;
    localparam logic [3:0] OPC_PING   = 4'd9;
    localparam logic [3:0] OPC_PONG   = 4'd10;

    localparam logic [6:0]  LEN_EXT16 = 7'd126;
    localparam logic [6:0]  LEN_EXT64 = 7'd127;
    localparam logic [63:0] LEN_LIMIT = 64'h0000_0000_FFFF_FFFB;
    localparam logic [3:0]  KEY_BYTES = 4'd4;

    typedef struct packed {
        logic        kind;
        logic [7:0]  pbyte;
        logic [1:0]  status;
        logic [3:0]  opcode;
        logic        fin;
        logic [2:0]  rsv;
        logic        masked;
        logic [31:0] length;
        logic        last_run;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } push_t;

endpackage

@@ hdl/wsdf_parse.sv @@
module wsdf_parse (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      data_byte,
    input  logic            buffer_last,
    output wsdf_pkg::push_t push
);
    import wsdf_pkg::*;

    logic [3:0]  pos_reg, pos_next;
    logic [7:0]  fhb_reg, fhb_next;
    logic [7:0]  msl_reg, msl_next;
    logic [63:0] ext_reg, ext_next;
    logic [31:0] key_reg, key_next;
    logic [31:0] cnt_reg, cnt_next;
    logic        err_reg, err_next;

    logic [3:0]  hdr_e, hdr_h, hdr_e_u, hdr_h_u;
    logic        emit;
    logic [7:0]  key_byte;
    logic [1:0]  st;
    logic [31:0] len;
    result_t     pay_r, stat_r;

    function automatic logic [3:0] ext_end(input logic [7:0] msl);
        logic [3:0] e;
        begin
            e = 4'd2;
            if (msl[6:0] == LEN_EXT16)
            begin
                e = 4'd4;
            end
            else if (msl[6:0] == LEN_EXT64)
            begin
                e = 4'd10;
            end
            return e;
        end
    endfunction

    function automatic logic opcode_ok(input logic [3:0] op);
        return op == OPC_TEXT || op == OPC_BINARY || op == OPC_CLOSE ||
               op == OPC_PING || op == OPC_PONG;
    endfunction

    always_comb
    begin
        hdr_e    = ext_end(msl_reg);
        hdr_h    = hdr_e + (msl_reg[7] ? KEY_BYTES : 4'd0);
        pos_next = pos_reg;
        fhb_next = fhb_reg;
        msl_next = msl_reg;
        ext_next = ext_reg;
        key_next = key_reg;
        cnt_next = cnt_reg;
        err_next = err_reg;
        emit     = 1'b0;
        case (cnt_reg[1:0])
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase

        if (pos_reg == 4'd0)
        begin
            fhb_next = data_byte;
            err_next = !opcode_ok(data_byte[3:0]);
            pos_next = 4'd1;
        end
        else if (pos_reg == 4'd1)
        begin
            msl_next = data_byte;
            ext_next = (data_byte[6:0] < LEN_EXT16) ? {57'd0, data_byte[6:0]} : 64'd0;
            pos_next = 4'd2;
        end
        else if (pos_reg < hdr_e)
        begin
            ext_next = {ext_reg[55:0], data_byte};
            pos_next = pos_reg + 4'd1;
        end
        else if (pos_reg < hdr_h)
        begin
            key_next = {key_reg[23:0], data_byte};
            pos_next = pos_reg + 4'd1;
        end
        else if (!err_reg && ext_reg <= LEN_LIMIT && {32'd0, cnt_reg} < ext_reg)
        begin
            emit     = 1'b1;
            cnt_next = cnt_reg + 32'd1;
        end

        // end-of-buffer status from the state after this byte
        hdr_e_u = ext_end(msl_next);
        hdr_h_u = hdr_e_u + (msl_next[7] ? KEY_BYTES : 4'd0);
        len     = 32'd0;
        if (pos_next < 4'd2)
        begin
            st = STAT_INCOMPLETE;
        end
        else if (err_next)
        begin
            st = STAT_ERROR;
        end
        else if ((msl_next[6:0] == LEN_EXT64 && pos_next < 4'd10) ||
                 (msl_next[6:0] == LEN_EXT16 && pos_next < 4'd4))
        begin
            st = STAT_INCOMPLETE;
        end
        else if (ext_next > LEN_LIMIT)
        begin
            st = STAT_ERROR;
        end
        else if (pos_next < hdr_h_u)
        begin
            st = STAT_ERROR;
        end
        else if ({32'd0, cnt_next} < ext_next)
        begin
            st = STAT_ERROR;
        end
        else
        begin
            st  = STAT_OK;
            len = ext_next[31:0];
        end

        pay_r          = '0;
        pay_r.kind     = KIND_PAYLOAD;
        pay_r.pbyte    = data_byte ^ key_byte;
        pay_r.last_run = !buffer_last;

        stat_r          = '0;
        stat_r.kind     = KIND_STATUS;
        stat_r.status   = st;
        stat_r.opcode   = fhb_next[3:0];
        stat_r.fin      = fhb_next[7];
        stat_r.rsv      = fhb_next[6:4];
        stat_r.masked   = msl_next[7];
        stat_r.length   = len;
        stat_r.last_run = 1'b1;

        push.count = {1'b0, emit} + {1'b0, buffer_last};
        push.r0    = emit ? pay_r : stat_r;
        push.r1    = stat_r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            fhb_reg <= '0;
            msl_reg <= '0;
            ext_reg <= '0;
            key_reg <= '0;
            cnt_reg <= '0;
            err_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (buffer_last)
            begin
                pos_reg <= '0;
                fhb_reg <= '0;
                msl_reg <= '0;
                ext_reg <= '0;
                key_reg <= '0;
                cnt_reg <= '0;
                err_reg <= 1'b0;
            end
            else
            begin
                pos_reg <= pos_next;
                fhb_reg <= fhb_next;
                msl_reg <= msl_next;
                ext_reg <= ext_next;
                key_reg <= key_next;
                cnt_reg <= cnt_next;
                err_reg <= err_next;
            end
        end
    end

endmodule

@@ hdl/wsdf_outq.sv @@
module wsdf_outq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  wsdf_pkg::push_t   push,
    output logic              space,
    output logic              valid,
    input  logic              ready,
    output wsdf_pkg::result_t head
);
    import wsdf_pkg::*;

    result_t    q_reg [3];
    result_t    q_next [3];
    result_t    q_sh [3];
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] base;
    logic [1:0] n;
    logic       pop;

    assign valid = cnt_reg != 2'd0;
    assign space = cnt_reg <= 2'd1;
    assign head  = q_reg[0];
    assign pop   = valid && ready;

    always_comb
    begin
        n        = accept ? push.count : 2'd0;
        base     = cnt_reg - {1'b0, pop};
        cnt_next = base + n;
        q_sh[0]  = pop ? q_reg[1] : q_reg[0];
        q_sh[1]  = pop ? q_reg[2] : q_reg[1];
        q_sh[2]  = q_reg[2];
        for (int i = 0; i < 3; i++)
        begin
            q_next[i] = q_sh[i];
            if (n != 2'd0 && base == 2'(i))
            begin
                q_next[i] = push.r0;
            end
            if (n == 2'd2 && base + 2'd1 == 2'(i))
            begin
                q_next[i] = push.r1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

endmodule

@@ hdl/websocket_frame_deframer.sv @@
// channel  | valid         | ready         | payload
// data     | data_valid    | data_ready    | data_byte, buffer_last
// result   | result_valid  | result_ready  | item_kind .. last_of_run
//
// One request per cycle while data_ready is high; each accepted byte is
// decoded in the cycle it is taken and its zero, one or two results land in
// a three-entry output queue. A byte that yields two results (final payload
// byte plus status) fills two entries. data_ready is high while the queue
// holds at most one result, so an output stall shows in data_ready next cycle.
// rst_n clears the frame state and empties the queue.
module websocket_frame_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    output logic        data_ready,
    input  logic [7:0]  data_byte,
    input  logic        buffer_last,
    output logic        result_valid,
    input  logic        result_ready,
    output logic        item_kind,
    output logic [7:0]  payload_byte,
    output logic [1:0]  frame_status,
    output logic [3:0]  frame_opcode,
    output logic        fin_bit,
    output logic [2:0]  reserved_bits,
    output logic        was_masked,
    output logic [31:0] decoded_length,
    output logic        last_of_run
);
    import wsdf_pkg::*;

    logic    accept;
    push_t   push;
    result_t head;

    assign accept = data_valid && data_ready;

    wsdf_parse u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (data_byte),
        .buffer_last (buffer_last),
        .push        (push)
    );

    wsdf_outq u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .accept(accept),
        .push  (push),
        .space (data_ready),
        .valid (result_valid),
        .ready (result_ready),
        .head  (head)
    );

    assign item_kind      = head.kind;
    assign payload_byte   = head.pbyte;
    assign frame_status   = head.status;
    assign frame_opcode   = head.opcode;
    assign fin_bit        = head.fin;
    assign reserved_bits  = head.rsv;
    assign was_masked     = head.masked;
    assign decoded_length = head.length;
    assign last_of_run    = head.last_run;

endmodule
